// File: design/jdas_pkg.sv
// Shared types, constants and band compare for the joystick axis scaler.
// No dependencies; used by jdas_div, jdas_axis_map and the top level.
`timescale 1ns / 1ps

package jdas_pkg;

  localparam int unsigned CAL_SAMPLES = 10;

  localparam int unsigned PCT_W  = 7;   // percent sample / centre width
  localparam int unsigned DZ_W   = 6;   // dead zone register width
  localparam int unsigned AXIS_W = 8;   // signed output byte
  localparam int unsigned NUM_W  = 14;  // divider dividend / quotient width
  localparam int unsigned DEN_W  = 7;   // divider divisor width

  localparam logic [DZ_W-1:0]  DZ_RESET   = 6'd3;
  localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;
  localparam logic [NUM_W-1:0] QUOT_SAT   = 14'd127;   // quotient on zero divisor
  localparam logic [AXIS_W-1:0] OFS_BELOW  = 8'd128;
  localparam logic [AXIS_W-1:0] OFS_INSIDE = 8'd127;

  localparam logic FUNC_CAL = 1'b0;
  localparam logic BTN_PRESSED = 1'b0;

  // where a position sits relative to the dead zone around a centre
  typedef struct packed {
    logic above;     // p > c + dz
    logic below;     // p < c - dz
    logic low_edge;  // p <= c - dz
  } band_t;

  // divider operands
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_op_t;

  function automatic band_t band_cmp(logic [PCT_W-1:0] p, logic [PCT_W-1:0] c,
                                     logic [DZ_W-1:0] dz);
    logic signed [PCT_W+1:0] sp;
    logic signed [PCT_W+1:0] hi;
    logic signed [PCT_W+1:0] lo;
    band_t b;
    sp = $signed({2'b00, p});
    hi = $signed({2'b00, c}) + $signed({3'b000, dz});
    lo = $signed({2'b00, c}) - $signed({3'b000, dz});
    b.above    = sp > hi;
    b.below    = sp < lo;
    b.low_edge = sp <= lo;
    return b;
  endfunction

endpackage

// File: design/jdas_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on jdas_pkg for operand widths.
`timescale 1ns / 1ps

module jdas_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  jdas_pkg::div_op_t                 op_i,
  output logic                              done_o,
  output logic [jdas_pkg::NUM_W-1:0]        quot_o
);

  localparam int unsigned CNT_W = $clog2(jdas_pkg::NUM_W + 1);

  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [jdas_pkg::DEN_W-1:0]  rem_q, rem_d;
  logic [jdas_pkg::DEN_W-1:0]  den_q, den_d;
  logic [jdas_pkg::NUM_W-1:0]  quo_q, quo_d;
  logic [jdas_pkg::DEN_W:0]    trial;

  assign trial = {rem_q, quo_q[jdas_pkg::NUM_W-1]};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(jdas_pkg::NUM_W);
      rem_d = '0;
      den_d = op_i.den;
      quo_d = op_i.num;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      if (trial >= {1'b0, den_q}) begin
        rem_d = jdas_pkg::DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[jdas_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[jdas_pkg::DEN_W-1:0];
        quo_d = {quo_q[jdas_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: design/jdas_axis_map.sv
// Axis scaling around the divider: builds the operands for one held position
// and turns the quotient into the saturated signed byte. Depends on jdas_pkg.
`timescale 1ns / 1ps

module jdas_axis_map (
  input  logic [jdas_pkg::PCT_W-1:0]  pos_i,
  input  logic [jdas_pkg::PCT_W-1:0]  center_i,
  input  logic [jdas_pkg::DZ_W-1:0]   dz_i,
  input  logic [jdas_pkg::NUM_W-1:0]  quot_i,
  output jdas_pkg::div_op_t           op_o,
  output logic [jdas_pkg::AXIS_W-1:0] axis_o
);

  localparam int unsigned V_W = jdas_pkg::NUM_W + 2;
  localparam logic signed [V_W-1:0] AXIS_MAX = V_W'(127);
  localparam logic signed [V_W-1:0] AXIS_MIN = -V_W'(128);

  jdas_pkg::band_t                band;
  logic [jdas_pkg::PCT_W-1:0]     diff;
  logic [jdas_pkg::PCT_W-1:0]     mul_src;
  logic                           neg;
  logic [jdas_pkg::AXIS_W-1:0]    ofs;
  logic [jdas_pkg::NUM_W-1:0]     qv;
  logic signed [V_W-1:0]          mag;
  logic signed [V_W-1:0]          sval;

  assign band = jdas_pkg::band_cmp(pos_i, center_i, dz_i);
  assign diff = pos_i - center_i;

  always_comb begin
    if (band.above) begin
      mul_src = diff;
      ofs     = '0;
      if (center_i > jdas_pkg::FULL_SCALE) begin
        op_o.den = center_i - jdas_pkg::FULL_SCALE;
        neg      = 1'b1;
      end else begin
        op_o.den = jdas_pkg::FULL_SCALE - center_i;
        neg      = 1'b0;
      end
    end else begin
      mul_src  = pos_i;
      op_o.den = center_i;
      neg      = 1'b0;
      ofs      = band.below ? jdas_pkg::OFS_BELOW : jdas_pkg::OFS_INSIDE;
    end
    // x * 127 as (x << 7) - x
    op_o.num = {mul_src, 7'b0} - {7'b0, mul_src};
  end

  // zero divisor saturates the quotient
  assign qv   = (op_o.den == '0) ? jdas_pkg::QUOT_SAT : quot_i;
  assign mag  = $signed({2'b00, qv});
  assign sval = (neg ? -mag : mag) - $signed({{(V_W-jdas_pkg::AXIS_W){1'b0}}, ofs});

  always_comb begin
    if (sval > AXIS_MAX) begin
      axis_o = 8'h7F;
    end else if (sval < AXIS_MIN) begin
      axis_o = 8'h80;
    end else begin
      axis_o = sval[jdas_pkg::AXIS_W-1:0];
    end
  end

endmodule

// File: design/joystick_deadzone_axis_scaler_top.sv
// Joystick axis scaler top: sequencer, calibration and hold state, output register.
// Depends on jdas_pkg, jdas_div and jdas_axis_map.
`timescale 1ns / 1ps

// Two-axis joystick conditioner on percent samples. A beat with tuser=0 is a
// calibration sample; after CAL_SAMPLES of them the truncated averages become
// the axis centres (a calibration beat after that restarts calibration). A
// beat with tuser=1 is an operating sample: with the button pressed (level 0)
// it lights one direction per axis outside the dead zone (centre +/- the
// dead_zone register, upper bound counted as inside) and holds the positions;
// if both axes sit inside, the held positions snap back to the centres. Every
// operating beat reports the held positions scaled to signed bytes. Beats that
// arrive before calibration give zero axes and calibrated=0. Throughput: every
// beat produces exactly one result beat. Beats that need arithmetic (final
// calibration sample, calibrated operating sample) run one shared 14-bit
// serial divider twice, once per axis (operand load, 14 quotient bits, done),
// then hand the result to the output register and go back to idle to take
// the next beat. Other beats go straight to the hand-over step. The output
// register lets the next beat in while a result waits on m_axis_tready; a
// second finished result holds the block until that register drains. The
// user is to write dead_zone through cfg_we_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this. Reset value is 3.
module joystick_deadzone_axis_scaler_top #(
  parameter int unsigned CAL_SAMPLES = jdas_pkg::CAL_SAMPLES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: dead_zone
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [6:0] x_percent, [13:7] y_percent,
                                      // [14] button_level, [15] zero
  input  logic        s_axis_tuser,   // func
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [0] led_north, [1] led_south,
                                      // [2] led_east, [3] led_west,
                                      // [4] active_led, [12:5] axis_x,
                                      // [20:13] axis_y, [21] button_out,
                                      // [22] calibrated, [23] zero
);

  localparam int unsigned SUM_W = $clog2(CAL_SAMPLES * 127 + 1);
  localparam int unsigned CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned PW    = jdas_pkg::PCT_W;
  localparam int unsigned AW    = jdas_pkg::AXIS_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV_X = 4'b0010,
    ST_DIV_Y = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic          calibrated;
    logic          button;
    logic [AW-1:0] axis_y;
    logic [AW-1:0] axis_x;
    logic          active;
    logic          west;
    logic          east;
    logic          south;
    logic          north;
  } result_t;

  state_e  state_q, state_d;
  logic    start_q, start_d;
  logic    cal_fin_q, cal_fin_d;      // dividing sums rather than scaling
  logic    is_cal_q, is_cal_d;
  logic    out_vld_q, out_vld_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_new;
  logic [SUM_W-1:0]        sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [PW-1:0]           cen_x_q, cen_x_d, cen_y_q, cen_y_d;
  logic [PW-1:0]           held_x_q, held_x_d, held_y_q, held_y_d;
  logic [jdas_pkg::DZ_W-1:0] dz_q;
  result_t                 res_q, res_d;
  logic [23:0]             out_q, out_d;

  logic          in_fire;
  logic [PW-1:0] x_in, y_in;
  logic          btn_in;
  jdas_pkg::band_t bx, by;
  logic          x_inside, y_inside;

  logic          sel_x;
  logic [PW-1:0] map_pos, map_cen;
  jdas_pkg::div_op_t map_op, div_op;
  logic [AW-1:0] map_axis;
  logic          div_done;
  logic [jdas_pkg::NUM_W-1:0] div_quot;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign x_in          = s_axis_tdata[6:0];
  assign y_in          = s_axis_tdata[13:7];
  assign btn_in        = s_axis_tdata[14];

  // lights classify the incoming sample against the current centres
  assign bx       = jdas_pkg::band_cmp(x_in, cen_x_q, dz_q);
  assign by       = jdas_pkg::band_cmp(y_in, cen_y_q, dz_q);
  assign x_inside = !bx.above && !bx.low_edge;
  assign y_inside = !by.above && !by.low_edge;

  assign cnt_new = (is_cal_q ? '0 : cnt_q) + CNT_W'(1);

  // shared divider, axis chosen by sequencer state
  assign sel_x   = (state_q == ST_DIV_X);
  assign map_pos = sel_x ? held_x_q : held_y_q;
  assign map_cen = sel_x ? cen_x_q : cen_y_q;

  jdas_axis_map u_map (
    .pos_i    (map_pos),
    .center_i (map_cen),
    .dz_i     (dz_q),
    .quot_i   (div_quot),
    .op_o     (map_op),
    .axis_o   (map_axis)
  );

  always_comb begin
    if (cal_fin_q) begin
      div_op.num = jdas_pkg::NUM_W'(sel_x ? sum_x_q : sum_y_q);
      div_op.den = jdas_pkg::DEN_W'(CAL_SAMPLES);
    end else begin
      div_op = map_op;
    end
  end

  jdas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .op_i    (div_op),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    start_d   = 1'b0;
    cal_fin_d = cal_fin_q;
    is_cal_d  = is_cal_q;
    cnt_d     = cnt_q;
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    cen_x_d   = cen_x_q;
    cen_y_d   = cen_y_q;
    held_x_d  = held_x_q;
    held_y_d  = held_y_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d        = '0;
          res_d.button = btn_in;
          if (s_axis_tuser == jdas_pkg::FUNC_CAL) begin
            is_cal_d = 1'b0;
            sum_x_d  = (is_cal_q ? '0 : sum_x_q) + SUM_W'(x_in);
            sum_y_d  = (is_cal_q ? '0 : sum_y_q) + SUM_W'(y_in);
            if (cnt_new == CNT_W'(CAL_SAMPLES)) begin
              cnt_d     = '0;
              cal_fin_d = 1'b1;
              start_d   = 1'b1;
              state_d   = ST_DIV_X;
            end else begin
              cnt_d   = cnt_new;
              state_d = ST_DONE;
            end
          end else if (is_cal_q) begin
            res_d.calibrated = 1'b1;
            cal_fin_d        = 1'b0;
            start_d          = 1'b1;
            state_d          = ST_DIV_X;
            if (btn_in == jdas_pkg::BTN_PRESSED) begin
              res_d.active = 1'b1;
              if (x_inside && y_inside) begin
                held_x_d = cen_x_q;
                held_y_d = cen_y_q;
              end else begin
                held_x_d    = x_in;
                held_y_d    = y_in;
                res_d.north = by.above;
                res_d.south = by.low_edge;
                res_d.east  = bx.above;
                res_d.west  = bx.low_edge;
              end
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          if (cal_fin_q) begin
            cen_x_d  = div_quot[PW-1:0];
            held_x_d = div_quot[PW-1:0];
          end else begin
            res_d.axis_x = map_axis;
          end
          start_d = 1'b1;
          state_d = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_done) begin
          if (cal_fin_q) begin
            cen_y_d          = div_quot[PW-1:0];
            held_y_d         = div_quot[PW-1:0];
            is_cal_d         = 1'b1;
            sum_x_d          = '0;
            sum_y_d          = '0;
            res_d.calibrated = 1'b1;
          end else begin
            res_d.axis_y = map_axis;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand over once the output register is free or draining
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = {1'b0, res_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      cal_fin_q <= 1'b0;
      is_cal_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      cen_x_q   <= '0;
      cen_y_q   <= '0;
      held_x_q  <= '0;
      held_y_q  <= '0;
      dz_q      <= jdas_pkg::DZ_RESET;
    end else begin
      state_q   <= state_d;
      start_q   <= start_d;
      cal_fin_q <= cal_fin_d;
      is_cal_q  <= is_cal_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
      cen_x_q   <= cen_x_d;
      cen_y_q   <= cen_y_d;
      held_x_q  <= held_x_d;
      held_y_q  <= held_y_d;
      if (cfg_we_i) begin
        dz_q <= cfg_wdata_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
